// File: design/pli_pkg.sv
package pli_pkg;

	localparam int NPTS  = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int DAT_W = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [1:0] RGN_LEFT   = 2'd0;
	localparam logic [1:0] RGN_INTERP = 2'd1;
	localparam logic [1:0] RGN_RIGHT  = 2'd2;

	// side data that rides along the divider
	typedef struct packed {
		logic [DAT_W-1:0] y0;
		logic             neg;
		logic [1:0]       region;
		logic [IDX_W-1:0] seg;
	} div_tag_t;

endpackage

// File: design/pli_div.sv
module pli_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [63:0]             in_prod,
	input  logic [31:0]             in_den,
	input  pli_pkg::div_tag_t       in_tag,
	output logic                    out_valid,
	output logic [31:0]             out_quo,
	output pli_pkg::div_tag_t       out_tag
);

	// restoring division, one quotient bit per stage; quotient is known to fit 32 bits
	logic              vld_s [0:32];
	logic [31:0]       rem_s [0:32];
	logic [31:0]       lo_s  [0:32];
	logic [31:0]       den_s [0:32];
	pli_pkg::div_tag_t tag_s [0:32];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = in_prod[63:32];
	assign lo_s[0]  = in_prod[31:0];
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < 32; k++) begin : g_step
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;

		assign trial = {rem_s[k], lo_s[k][31]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[31:0] : trial[31:0];
				lo_s[k+1]  <= {lo_s[k][30:0], ge};
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[32];
	assign out_quo   = lo_s[32];
	assign out_tag   = tag_s[32];

endmodule

// File: design/piecewise_linear_interpolator.sv
// channel  | dir | handshake               | contents
// s_axis   | in  | s_axis_tvalid/tready    | tdata: point_index, x_value, y_value; tuser: cmd
// m_axis   | out | m_axis_tvalid/tready    | tdata: y_result, segment; tuser: region
// cfg      | in  | cfg_valid/cfg_ready     | cfg_data: point_count
//
// one word accepted per cycle while the output side takes words; pipeline stages in order:
// (input reg, compare, select, differences, multiply, 32 divider steps, output reg)
// latency is set mostly by the 32-stage restoring divider, one quotient bit per stage
// the whole pipeline advances together: it stalls only when the output word waits
// reset clears valid bits and sets point_count to 1; the breakpoint table is not cleared
// loads write the table when they leave the input register, so evaluations see program order
module piecewise_linear_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // point_index[3:0], x_value[35:4], y_value[67:36], zeros
	input  logic [0:0]  s_axis_tuser,  // cmd[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // y_result[31:0], segment[35:32], zeros
	output logic [1:0]  m_axis_tuser,  // region[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data       // point_count
);

	localparam int N  = pli_pkg::NPTS;
	localparam int IW = pli_pkg::IDX_W;
	localparam int DW = pli_pkg::DAT_W;

	logic adv;
	logic [pli_pkg::CNT_W-1:0] cnt_q;

	// breakpoint table
	logic [DW-1:0] bpx_q [0:N-1];
	logic [DW-1:0] bpy_q [0:N-1];

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= pli_pkg::CNT_W'(1);
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	// stage 1: input register
	logic          vld_s1;
	logic          cmd_s1;
	logic [IW-1:0] idx_s1;
	logic [DW-1:0] x_s1;
	logic [DW-1:0] y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= s_axis_tuser[0];
			idx_s1 <= s_axis_tdata[3:0];
			x_s1   <= s_axis_tdata[35:4];
			y_s1   <= s_axis_tdata[67:36];
		end
	end

	// table write as a load leaves stage 1
	always_ff @(posedge clk) begin
		if (adv && vld_s1 && cmd_s1 == pli_pkg::CMD_LOAD) begin
			bpx_q[idx_s1] <= x_s1;
			bpy_q[idx_s1] <= y_s1;
		end
	end

	// stage 2: parallel compares against every breakpoint
	logic          vld_s2;
	logic [N-1:0]  gt_s2;
	logic [DW-1:0] x_s2;
	logic [N-1:0]  gt_c;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			gt_c[k] = $signed(bpx_q[k]) > $signed(x_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1 && cmd_s1 == pli_pkg::CMD_EVAL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gt_s2 <= gt_c;
			x_s2  <= x_s1;
		end
	end

	// stage 3: first greater breakpoint among used entries, select neighbors
	logic [pli_pkg::CNT_W-1:0] n_c;
	logic [IW-1:0] last_c;
	logic [N-1:0]  used_c;
	logic [N-1:0]  hit_c;
	logic [N-1:0]  first_c;
	logic [N-1:0]  prev_c;
	logic [IW-1:0] enc_c;
	logic [DW-1:0] x0_c, x1_c, y0_c, y1_c, ylast_c;
	logic [1:0]    rgn_c;
	logic [IW-1:0] seg_c;
	logic [DW-1:0] ysel_c;

	always_comb begin
		if (cnt_q == '0) begin
			n_c = pli_pkg::CNT_W'(1);
		end else if (cnt_q > pli_pkg::CNT_W'(N)) begin
			n_c = pli_pkg::CNT_W'(N);
		end else begin
			n_c = cnt_q;
		end
		last_c = IW'(n_c - pli_pkg::CNT_W'(1));
		for (int k = 0; k < N; k++) begin
			used_c[k] = pli_pkg::CNT_W'(k) < n_c;
		end
		hit_c   = gt_s2 & used_c;
		first_c = hit_c & (~hit_c + N'(1));
		prev_c  = first_c >> 1;
		enc_c   = '0;
		x0_c    = '0;
		x1_c    = '0;
		y0_c    = '0;
		y1_c    = '0;
		ylast_c = '0;
		for (int k = 0; k < N; k++) begin
			enc_c   = enc_c | (first_c[k] ? IW'(k) : '0);
			x0_c    = x0_c | (prev_c[k] ? bpx_q[k] : '0);
			y0_c    = y0_c | (prev_c[k] ? bpy_q[k] : '0);
			x1_c    = x1_c | (first_c[k] ? bpx_q[k] : '0);
			y1_c    = y1_c | (first_c[k] ? bpy_q[k] : '0);
			ylast_c = ylast_c | ((IW'(k) == last_c) ? bpy_q[k] : '0);
		end
		if (hit_c == '0) begin
			rgn_c  = pli_pkg::RGN_RIGHT;
			seg_c  = last_c;
			ysel_c = ylast_c;
		end else if (first_c[0]) begin
			rgn_c  = pli_pkg::RGN_LEFT;
			seg_c  = '0;
			ysel_c = y1_c;
		end else begin
			rgn_c  = pli_pkg::RGN_INTERP;
			seg_c  = enc_c;
			ysel_c = y0_c;
		end
	end

	logic          vld_s3;
	logic [1:0]    rgn_s3;
	logic [IW-1:0] seg_s3;
	logic [DW-1:0] x_s3, x0_s3, x1_s3, y0_s3, y1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgn_s3 <= rgn_c;
			seg_s3 <= seg_c;
			x_s3   <= x_s2;
			x0_s3  <= x0_c;
			x1_s3  <= x1_c;
			y0_s3  <= ysel_c;
			y1_s3  <= y1_c;
		end
	end

	// stage 4: differences and magnitude of the rise
	logic [DW:0]   dy_c;
	logic          vld_s4;
	logic [DW-1:0] num_s4, den_s4, mag_s4;
	pli_pkg::div_tag_t tag_s4;

	assign dy_c = {y1_s3[DW-1], y1_s3} - {y0_s3[DW-1], y0_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4        <= x_s3 - x0_s3;
			den_s4        <= x1_s3 - x0_s3;
			mag_s4        <= dy_c[DW] ? DW'(-dy_c) : dy_c[DW-1:0];
			tag_s4.y0     <= y0_s3;
			tag_s4.neg    <= dy_c[DW];
			tag_s4.region <= rgn_s3;
			tag_s4.seg    <= seg_s3;
		end
	end

	// stage 5: product of rise and run
	logic          vld_s5;
	logic [63:0]   prod_s5;
	logic [DW-1:0] den_s5;
	pli_pkg::div_tag_t tag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5 <= 64'(mag_s4) * 64'(num_s4);
			den_s5  <= den_s4;
			tag_s5  <= tag_s4;
		end
	end

	// divider stages
	logic              dv_vld;
	logic [31:0]       dv_quo;
	pli_pkg::div_tag_t dv_tag;

	pli_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s5),
		.in_prod   (prod_s5),
		.in_den    (den_s5),
		.in_tag    (tag_s5),
		.out_valid (dv_vld),
		.out_quo   (dv_quo),
		.out_tag   (dv_tag)
	);

	// output register: apply quotient for interpolated words, else pass the clamp value
	logic [DW-1:0] res_c;

	always_comb begin
		if (dv_tag.region != pli_pkg::RGN_INTERP) begin
			res_c = dv_tag.y0;
		end else if (dv_tag.neg) begin
			res_c = dv_tag.y0 - dv_quo;
		end else begin
			res_c = dv_tag.y0 + dv_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {4'd0, dv_tag.seg, res_c};
			m_axis_tuser <= dv_tag.region;
		end
	end

`ifndef ASSERT_OFF
	a_left_seg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == pli_pkg::RGN_LEFT |-> m_axis_tdata[35:32] == '0)
		else $error("left clamp with nonzero segment");
	a_interp_seg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == pli_pkg::RGN_INTERP |-> m_axis_tdata[35:32] != '0)
		else $error("interpolated word with segment zero");
	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("invalid region");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1) && $stable(vld_s5))
		else $error("pipeline moved during stall");
`endif

endmodule

// File: sim/pli_checker.sv
module pli_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	typedef struct packed {
		logic [pli_pkg::DAT_W-1:0] y;
		logic [1:0]                region;
		logic [pli_pkg::IDX_W-1:0] seg;
	} pli_result_t;

	logic signed [pli_pkg::DAT_W-1:0] tbl_x [pli_pkg::NPTS];
	logic signed [pli_pkg::DAT_W-1:0] tbl_y [pli_pkg::NPTS];
	logic [pli_pkg::CNT_W-1:0]        used_points;
	pli_result_t                      awaited [$];

	// clamp search plus interpolation, quotient truncated toward zero
	function automatic pli_result_t eval_at(logic signed [pli_pkg::DAT_W-1:0] xq);
		int          n;
		int          i;
		longint      x0, x1, y0, y1, dy;
		bit          neg;
		bit [63:0]   mag, nx, den, q;
		pli_result_t r;
		n = (used_points == 0) ? 1 :
			(used_points > pli_pkg::NPTS) ? pli_pkg::NPTS : int'(used_points);
		i = 0;
		while (i < n && !(tbl_x[i] > xq))
			i++;
		if (i >= n) begin
			r.seg    = pli_pkg::IDX_W'(n - 1);
			r.y      = tbl_y[n - 1];
			r.region = pli_pkg::RGN_RIGHT;
		end else if (i == 0) begin
			r.seg    = '0;
			r.y      = tbl_y[0];
			r.region = pli_pkg::RGN_LEFT;
		end else begin
			x0  = longint'(tbl_x[i-1]);
			x1  = longint'(tbl_x[i]);
			y0  = longint'(tbl_y[i-1]);
			y1  = longint'(tbl_y[i]);
			dy  = y1 - y0;
			neg = dy < 0;
			mag = neg ? -dy : dy;
			nx  = longint'(xq) - x0;
			den = x1 - x0;
			q   = (mag * nx) / den;
			r.y      = neg ? pli_pkg::DAT_W'(y0 - longint'(q)) :
				pli_pkg::DAT_W'(y0 + longint'(q));
			r.region = pli_pkg::RGN_INTERP;
			r.seg    = pli_pkg::IDX_W'(i);
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] want, logic [31:0] got);
		$display("mismatch %s: expected %h, got %h", what, want, got);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		checked    = 0;
		pending    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		pli_result_t exp_r;
		pli_result_t got_r;
		if (!arst_n) begin
			used_points = pli_pkg::CNT_W'(1);
			awaited.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				used_points = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0] == pli_pkg::CMD_LOAD) begin
					tbl_x[s_axis_tdata[3:0]] = s_axis_tdata[35:4];
					tbl_y[s_axis_tdata[3:0]] = s_axis_tdata[67:36];
				end else
					awaited.insert(awaited.size(), eval_at(s_axis_tdata[35:4]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_r = '{m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[35:32]};
				if (awaited.size() == 0) begin
					report("unexpected result word", '0, got_r.y);
				end else begin
					exp_r = awaited.pop_front();
					checked++;
					if (got_r.y != exp_r.y)
						report("y_result", exp_r.y, got_r.y);
					if (got_r.region != exp_r.region)
						report("region", 32'(exp_r.region), 32'(got_r.region));
					if (got_r.seg != exp_r.seg)
						report("segment", 32'(exp_r.seg), 32'(got_r.seg));
				end
			end
			pending = awaited.size();
		end
	end

endmodule

// File: sim/testbench.sv
module testbench;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;   // point_index[3:0], x_value[35:4], y_value[67:36], zeros
	logic [0:0]  s_axis_tuser;   // cmd[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // y_result[31:0], segment[35:32], zeros
	logic [1:0]  m_axis_tuser;   // region[1:0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	int          fail_count;
	int          pending;
	int          checked;

	// stimulus-side copy of the breakpoint x values, used to aim queries
	logic signed [31:0] shadow_x [pli_pkg::NPTS];
	bit                 calm;      // no idling on either side
	bit                 hold_req;  // ask the receiver for a long stall
	int                 words_sent;
	int                 cfg_writes;
	int                 cycles;

	piecewise_linear_interpolator dut (.*);

	pli_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else
				m_axis_tready <= 1;
		end
	end

	// one input word; called at a rising edge, returns at the edge that took it
	task automatic send_word(logic c, logic [3:0] idx, logic [31:0] xv, logic [31:0] yv);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {4'b0, yv, xv, idx};
		s_axis_tuser  <= c;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic load_point(logic [3:0] idx, logic [31:0] xv, logic [31:0] yv);
		shadow_x[idx] = xv;
		send_word(pli_pkg::CMD_LOAD, idx, xv, yv);
	endtask

	task automatic eval_x(logic [31:0] xv);
		send_word(pli_pkg::CMD_EVAL, '0, xv, '0);
	endtask

	// write point_count only once the pipeline has drained
	task automatic set_points(logic [4:0] v);
		s_axis_tvalid <= 0;
		@(negedge clk);
		wait (pending == 0);
		repeat (48) @(posedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 0;
		cfg_writes++;
	endtask

	// ascending breakpoints, starting in the lowest quarter of the signed range
	task automatic load_sorted_table();
		longint xa;
		xa = -64'sd2147483648 + $urandom_range(0, 32'h3fffffff);
		for (int k = 0; k < pli_pkg::NPTS; k++) begin
			load_point(4'(k), xa[31:0], $urandom);
			xa += $urandom_range(1, 32'h07ffffff);
		end
	endtask

	task automatic load_random_table();
		for (int k = 0; k < pli_pkg::NPTS; k++)
			load_point(4'(k), $urandom, $urandom);
	endtask

	// query aimed at breakpoints, just below them, between them, or anywhere
	function automatic logic [31:0] pick_query();
		int k;
		k = $urandom_range(0, pli_pkg::NPTS - 1);
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return shadow_x[k];
			2: return shadow_x[k] - 1;
			3: return shadow_x[k] + $urandom_range(0, 32'h00ffffff);
			default: return 32'((longint'(shadow_x[k]) +
				longint'(shadow_x[(k + 1) % pli_pkg::NPTS])) / 2);
		endcase
	endfunction

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 0;
		cfg_data      = '0;
		calm          = 0;
		hold_req      = 0;
		words_sent    = 0;
		cfg_writes    = 0;
		cycles        = 0;
		arst_n        = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every entry written before any evaluation
		load_sorted_table();
		set_points(16);
		eval_x(32'h80000000);
		eval_x(32'h7fffffff);
		eval_x(shadow_x[0] - 1);
		eval_x(shadow_x[0]);
		eval_x(shadow_x[7] + 1);
		eval_x(shadow_x[15]);
		eval_x(32'((longint'(shadow_x[3]) + longint'(shadow_x[4])) / 2));

		// widest slope the fields allow, falling
		load_point(0, 32'h80000000, 32'h7fffffff);
		load_point(1, 32'h7fffffff, 32'h80000000);
		set_points(2);
		eval_x(32'h00000000);
		eval_x(32'hffffffff);
		eval_x(32'h7ffffffe);
		eval_x(32'h80000001);

		// count of zero acts as one, counts above the table saturate
		set_points(0);
		eval_x($urandom);
		set_points(1);
		eval_x(32'h7fffffff);
		set_points(31);
		eval_x(32'h7fffffff);
		eval_x(32'h80000000);
		set_points(17);
		eval_x($urandom);

		// random phases: mostly sorted tables, some unsorted
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7)
				calm = 1;
			if ($urandom_range(0, 3) == 0)
				load_random_table();
			else
				load_sorted_table();
			set_points(5'($urandom_range(0, 31)));
			if (ph == 3)
				hold_req = 1;
			for (int n = 0; n < 32; n++) begin
				if (ph == 5 && n == 20) begin
					s_axis_tvalid <= 0;
					@(negedge clk);
					wait (pending == 0);
					@(posedge clk);
				end
				if ($urandom_range(0, 4) == 0)
					load_point(4'($urandom_range(0, pli_pkg::NPTS - 1)), $urandom, $urandom);
				else
					eval_x(pick_query());
			end
		end
		s_axis_tvalid <= 0;

		@(negedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		$display("sent %0d words over %0d point_count settings", words_sent, cfg_writes);
		$display("checked %0d results, %0d mismatches", checked, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
